@@ hdl/sle_pkg.sv @@
// shared types, constants and codes of the sequential list engine
package sle_pkg;

    // list capacity and derived widths
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // field widths
    localparam int WORD_W = 32;
    localparam int MODE_W = 3;
    localparam int POS_W  = 6;
    localparam int STAT_W = 3;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FIND       = 3'd6;
    localparam logic [MODE_W-1:0] MODE_MODIFY     = 3'd7;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // walk plans chosen once a request is decoded
    localparam logic [1:0] PLAN_NONE = 2'd0;
    localparam logic [1:0] PLAN_UP   = 2'd1;
    localparam logic [1:0] PLAN_DOWN = 2'd2;
    localparam logic [1:0] PLAN_FIND = 2'd3;

    // fill count adjustment at retire
    localparam logic [1:0] DELTA_NONE = 2'd0;
    localparam logic [1:0] DELTA_INC  = 2'd1;
    localparam logic [1:0] DELTA_DEC  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   found_index;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic plan;
        logic walk_up;
        logic walk_down;
        logic walk_find;
        logic retire;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] plan;
        logic       walk_done;
        logic       out_free;
    } sts_t;

endpackage

@@ hdl/sequential_list_engine.sv @@
// top level of the sequential list engine: controller, datapath and ports
//
// ordered list of up to 64 signed 32-bit words held in a single ram with a
// registered read port. each request word on req carries one operation (push
// back, pop back, push front, pop front, insert with shift-up, erase with
// shift-down, find first equal, modify) and gives exactly one response word on
// rsp with the status, the found index (zero unless a find hits) and the fill
// count after the operation. one request is worked on at a time: a request is
// taken in, decoded, walked through the ram, which moves or compares one entry
// per cycle, and retired once the output register is free; pop back and modify
// need no walk. the longest request is a find that misses on a full list, its
// walk bounded by the single ram read port feeding the shift and compare loop.
// a finished response waits in its own output register, so the next request is
// taken while the previous response is still stalled. reset empties the list at
// once; the ram holds no reset value and only entries below the fill count are
// ever read.
module sequential_list_engine (
    input  logic          clk,
    input  logic          rst_n,
    // request channel
    input  logic          req_valid,
    output logic          req_stall,
    input  sle_pkg::req_t req,
    // response channel
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sle_pkg::rsp_t rsp
);

    // command and status between controller and datapath
    sle_pkg::cmd_t cmd;
    sle_pkg::sts_t sts;

    // sequencer: accept, decode, walk, retire
    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // entry store, walk pointer, fill count and response register
    sle_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

@@ hdl/sle_ram.sv @@
// generic simple dual-port ram with registered read
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/sle_ctrl.sv @@
// controller state machine of the sequential list engine
module sle_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sle_pkg::sts_t sts,
    output sle_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PLAN   = 3'd1;
    localparam logic [2:0] S_UP     = 3'd2;
    localparam logic [2:0] S_DOWN   = 3'd3;
    localparam logic [2:0] S_FIND   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                cmd.plan = 1'b1;
                unique case (sts.plan)
                    sle_pkg::PLAN_UP:   state_next = S_UP;
                    sle_pkg::PLAN_DOWN: state_next = S_DOWN;
                    sle_pkg::PLAN_FIND: state_next = S_FIND;
                    default:            state_next = S_FINISH;
                endcase
            end
            S_UP:
            begin
                cmd.walk_up = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DOWN:
            begin
                cmd.walk_down = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FIND:
            begin
                cmd.walk_find = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.retire = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/sle_dp.sv @@
// datapath of the sequential list engine: entry store, walk pointer, result register
module sle_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  sle_pkg::req_t req,
    input  sle_pkg::cmd_t cmd,
    output sle_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sle_pkg::rsp_t rsp
);

    localparam int AW = sle_pkg::ADDR_W;
    localparam int CW = sle_pkg::COUNT_W;
    localparam int WW = sle_pkg::WORD_W;

    sle_pkg::req_t          req_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CW-1:0]          idx_reg;
    logic [CW-1:0]          idx_next;
    logic [CW-1:0]          tgt_reg;
    logic [sle_pkg::STAT_W-1:0] stat_reg;
    logic [sle_pkg::STAT_W-1:0] stat_next;
    logic [AW-1:0]          found_reg;
    logic [AW-1:0]          found_next;
    logic [1:0]             delta_reg;
    logic                   pend_reg;
    logic                   pend_next;
    logic [AW-1:0]          pend_addr_reg;
    logic [AW-1:0]          pend_addr_next;
    logic                   out_valid_reg;
    sle_pkg::rsp_t          out_data_reg;

    // decode of the held request
    logic [1:0]             plan_code;
    logic [sle_pkg::STAT_W-1:0] plan_stat;
    logic [1:0]             plan_delta;
    logic [CW-1:0]          plan_idx;
    logic [CW-1:0]          plan_tgt;
    logic                   plan_write;
    logic [CW-1:0]          pos_ext;
    logic [CW-1:0]          ins_pos;
    logic [CW-1:0]          ers_pos;
    logic                   is_full;
    logic                   is_empty;

    // ram port signals
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [WW-1:0]          ram_rdata;

    logic [CW-1:0]          idx_dec;
    logic [CW-1:0]          idx_inc;
    logic                   issue;
    logic                   hit;
    logic                   walk_done;
    logic [WW-1:0]          word;

    assign pos_ext  = CW'(req_reg.position);
    assign is_full  = (count_reg == CW'(sle_pkg::DEPTH));
    assign is_empty = (count_reg == '0);
    assign word     = WW'($unsigned(req_reg.value));
    assign idx_dec  = idx_reg - CW'(1);
    assign idx_inc  = idx_reg + CW'(1);

    always_comb
    begin
        plan_code  = sle_pkg::PLAN_NONE;
        plan_stat  = sle_pkg::ST_OK;
        plan_delta = sle_pkg::DELTA_NONE;
        plan_idx   = '0;
        plan_tgt   = '0;
        plan_write = 1'b0;
        ins_pos    = pos_ext;
        ers_pos    = pos_ext;
        unique case (req_reg.mode)
            sle_pkg::MODE_PUSH_BACK:  ins_pos = count_reg;
            sle_pkg::MODE_PUSH_FRONT: ins_pos = '0;
            sle_pkg::MODE_POP_FRONT:  ers_pos = '0;
            default:                  ins_pos = pos_ext;
        endcase
        unique case (req_reg.mode) inside
            sle_pkg::MODE_PUSH_BACK, sle_pkg::MODE_PUSH_FRONT, sle_pkg::MODE_INSERT:
            begin
                if (ins_pos > count_reg)
                begin
                    plan_stat = sle_pkg::ST_BADPOS;
                end
                else if (is_full)
                begin
                    plan_stat = sle_pkg::ST_FULL;
                end
                else
                begin
                    plan_code  = sle_pkg::PLAN_UP;
                    plan_delta = sle_pkg::DELTA_INC;
                    plan_idx   = count_reg;
                    plan_tgt   = ins_pos;
                end
            end
            sle_pkg::MODE_POP_BACK:
            begin
                if (is_empty)
                begin
                    plan_stat = sle_pkg::ST_EMPTY;
                end
                else
                begin
                    plan_delta = sle_pkg::DELTA_DEC;
                end
            end
            sle_pkg::MODE_POP_FRONT, sle_pkg::MODE_ERASE:
            begin
                if (is_empty)
                begin
                    plan_stat = sle_pkg::ST_EMPTY;
                end
                else if (ers_pos >= count_reg)
                begin
                    plan_stat = sle_pkg::ST_BADPOS;
                end
                else
                begin
                    plan_code  = sle_pkg::PLAN_DOWN;
                    plan_delta = sle_pkg::DELTA_DEC;
                    plan_idx   = ers_pos + CW'(1);
                end
            end
            sle_pkg::MODE_FIND:
            begin
                plan_code = sle_pkg::PLAN_FIND;
                plan_stat = sle_pkg::ST_NOTFOUND;
            end
            sle_pkg::MODE_MODIFY:
            begin
                if (is_empty)
                begin
                    plan_stat = sle_pkg::ST_EMPTY;
                end
                else if (pos_ext >= count_reg)
                begin
                    plan_stat = sle_pkg::ST_BADPOS;
                end
                else
                begin
                    plan_write = 1'b1;
                end
            end
        endcase
    end

    // one entry moved, or compared, per cycle; modify writes its word during decode
    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = idx_reg[AW-1:0];
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        stat_next      = stat_reg;
        found_next     = found_reg;
        issue          = 1'b0;
        hit            = 1'b0;
        walk_done      = 1'b0;
        if (cmd.plan)
        begin
            ram_we    = plan_write;
            ram_waddr = pos_ext[AW-1:0];
            ram_wdata = word;
        end
        else if (cmd.walk_up)
        begin
            issue = (idx_reg > tgt_reg);
            if (issue)
            begin
                ram_raddr      = idx_dec[AW-1:0];
                idx_next       = idx_dec;
                pend_next      = 1'b1;
                pend_addr_next = idx_reg[AW-1:0];
            end
            if (pend_reg)
            begin
                ram_we = 1'b1;
            end
            else if (!issue)
            begin
                // shifting finished: drop the new word into the gap
                ram_we    = 1'b1;
                ram_waddr = tgt_reg[AW-1:0];
                ram_wdata = word;
                walk_done = 1'b1;
            end
        end
        else if (cmd.walk_down)
        begin
            issue = (idx_reg < count_reg);
            if (issue)
            begin
                ram_raddr      = idx_reg[AW-1:0];
                idx_next       = idx_inc;
                pend_next      = 1'b1;
                pend_addr_next = idx_dec[AW-1:0];
            end
            ram_we    = pend_reg;
            walk_done = !issue && !pend_reg;
        end
        else if (cmd.walk_find)
        begin
            hit = pend_reg && (ram_rdata == word);
            if (hit)
            begin
                stat_next  = sle_pkg::ST_OK;
                found_next = pend_addr_reg;
                walk_done  = 1'b1;
            end
            else
            begin
                issue = (idx_reg < count_reg);
                if (issue)
                begin
                    ram_raddr      = idx_reg[AW-1:0];
                    idx_next       = idx_inc;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                end
                walk_done = !issue && !pend_reg;
            end
        end
    end

    always_comb
    begin
        case (delta_reg)
            sle_pkg::DELTA_INC: count_next = count_reg + CW'(1);
            sle_pkg::DELTA_DEC: count_next = count_reg - CW'(1);
            default:            count_next = count_reg;
        endcase
    end

    sle_ram #(
        .WIDTH (WW),
        .DEPTH (sle_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.plan)
        begin
            idx_reg   <= plan_idx;
            tgt_reg   <= plan_tgt;
            stat_reg  <= plan_stat;
            delta_reg <= plan_delta;
            found_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            stat_reg  <= stat_next;
            found_reg <= found_next;
        end
        pend_addr_reg <= pend_addr_next;
        if (cmd.retire)
        begin
            out_data_reg.status      <= stat_reg;
            out_data_reg.found_index <= sle_pkg::POS_W'(found_reg);
            out_data_reg.count       <= count_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.plan ? 1'b0 : pend_next;
            if (cmd.retire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.plan      = plan_code;
    assign sts.walk_done = walk_done;
    assign sts.out_free  = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

@@ verif/tb_sequential_list_engine.sv @@
// self-checking testbench for the sequential list engine: request driver, response monitor, list predictor
module tb_sequential_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    // run shape
    localparam int unsigned ITEM_TOTAL   = 700;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned HOLD_AT      = 350;   // request words accepted before the long hold-off
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 100;   // a full-length walk plus margin
    localparam int unsigned REPORT_CAP   = 40;
    localparam int unsigned POS_MAX      = (1 << POS_W) - 1;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // the random traffic steers the list through fill, busy-near-full, drain and busy-near-empty
    typedef enum {PH_FILL, PH_HIGH, PH_DRAIN, PH_LOW} traffic_phase_e;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // request words waiting to be offered, and responses the list should give back
    req_t pending_q[$];
    rsp_t expected_rsp_q[$];

    // predicted list contents
    logic signed [WORD_W-1:0] list_words [DEPTH] = '{default: '0};
    int unsigned              list_fill = 0;

    // generator side: fill count followed as words are queued, plus recently stored values
    int unsigned              gen_fill = 0;
    logic signed [WORD_W-1:0] recent_vals[$];

    int unsigned words_sent  = 0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    int unsigned hold_left   = 0;
    logic        hold_done   = 1'b0;
    rsp_t        rsp_want;

    sequential_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (fail_count < REPORT_CAP)
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // place a word at pos, shifting the entries above it up by one
    function automatic logic [STAT_W-1:0] list_place(int unsigned pos,
                                                     logic signed [WORD_W-1:0] w);
        int unsigned k;
        // a bad position wins over a full list
        if (pos > list_fill)
            return ST_BADPOS;
        if (list_fill >= DEPTH)
            return ST_FULL;
        for (k = list_fill; k > pos; k--)
            list_words[k] = list_words[k - 1];
        list_words[pos] = w;
        list_fill++;
        return ST_OK;
    endfunction

    // drop the word at pos, shifting only the valid entries above it down
    function automatic logic [STAT_W-1:0] list_remove(int unsigned pos);
        int unsigned k;
        if (list_fill == 0)
            return ST_EMPTY;
        if (pos >= list_fill)
            return ST_BADPOS;
        for (k = pos; k + 1 < list_fill; k++)
            list_words[k] = list_words[k + 1];
        list_fill--;
        return ST_OK;
    endfunction

    // apply one request to the predicted list and give the response it should produce
    function automatic rsp_t list_apply(req_t r);
        rsp_t        o;
        int unsigned k;
        o = '0;
        o.status = ST_OK;
        case (r.mode)
            MODE_PUSH_BACK:  o.status = list_place(list_fill, r.value);
            MODE_PUSH_FRONT: o.status = list_place(0, r.value);
            MODE_INSERT:     o.status = list_place(r.position, r.value);
            MODE_POP_FRONT:  o.status = list_remove(0);
            MODE_ERASE:      o.status = list_remove(r.position);
            MODE_POP_BACK:
            begin
                if (list_fill == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    // the vacated slot is cleared
                    list_fill--;
                    list_words[list_fill] = '0;
                end
            end
            MODE_FIND:
            begin
                // first match only; an empty list simply misses
                o.status = ST_NOTFOUND;
                for (k = 0; k < list_fill; k++)
                begin
                    if (list_words[k] == r.value)
                    begin
                        o.status      = ST_OK;
                        o.found_index = POS_W'(k);
                        break;
                    end
                end
            end
            default:
            begin
                // modify
                if (list_fill == 0)
                    o.status = ST_EMPTY;
                else if (r.position >= list_fill)
                    o.status = ST_BADPOS;
                else
                    list_words[r.position] = r.value;
            end
        endcase
        o.count = COUNT_W'(list_fill);
        return o;
    endfunction

    // queue one request word and follow the fill count it will leave behind
    function automatic void add_req(logic [MODE_W-1:0] m, int unsigned p,
                                    logic signed [WORD_W-1:0] v);
        req_t r;
        r.mode     = m;
        r.position = POS_W'(p);
        r.value    = v;
        pending_q.push_back(r);
        case (m)
            MODE_PUSH_BACK, MODE_PUSH_FRONT:
            begin
                if (gen_fill < DEPTH)
                    gen_fill++;
            end
            MODE_INSERT:
            begin
                if (p <= gen_fill && gen_fill < DEPTH)
                    gen_fill++;
            end
            MODE_POP_BACK, MODE_POP_FRONT:
            begin
                if (gen_fill != 0)
                    gen_fill--;
            end
            MODE_ERASE:
            begin
                if (p < gen_fill)
                    gen_fill--;
            end
            default: ;
        endcase
        // remember stored values so that finds tend to hit
        if (m != MODE_FIND && m != MODE_POP_BACK && m != MODE_POP_FRONT && m != MODE_ERASE)
        begin
            recent_vals.push_back(v);
            if (recent_vals.size() > 16)
                void'(recent_vals.pop_front());
        end
    endfunction

    // request driver: bursts of random length with random gaps, payload held while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp_q.push_back(list_apply(req));
                words_sent <= words_sent + 1;
            end
            // a new word may only be offered once the current one has gone
            if (!req_valid || !req_stall)
            begin
                if (gap_left != 0)
                begin
                    req_valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end
                else if (pending_q.size() != 0)
                begin
                    req       <= pending_q.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        // short gaps sit inside a walk, long ones land after it on any phase
                        burst_left <= $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4: gap_left <= $urandom_range(0, 2);
                            5, 6, 7:       gap_left <= $urandom_range(3, 24);
                            default:       gap_left <= $urandom_range(25, 90);
                        endcase
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here, so the engine backs up and stalls its input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && words_sent == HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // response monitor: compare against the oldest expectation, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch("response word with none outstanding, status", rsp.status, 0);
                else
                begin
                    rsp_want = expected_rsp_q.pop_front();
                    if (rsp.status !== rsp_want.status)
                        report_mismatch("status", rsp.status, rsp_want.status);
                    if (rsp.found_index !== rsp_want.found_index)
                        report_mismatch("found_index", rsp.found_index, rsp_want.found_index);
                    if (rsp.count !== rsp_want.count)
                        report_mismatch("count", rsp.count, rsp_want.count);
                end
            end
            // stall pattern chosen by cycle_count[9:7], including stretches with none
            case (cycle_count[9:7])
                3'd0, 3'd1: rsp_stall <= (hold_left != 0);
                3'd2:       rsp_stall <= (hold_left != 0) || ($urandom_range(0, 3) == 0);
                3'd3:       rsp_stall <= (hold_left != 0) || ($urandom_range(0, 1) == 0);
                3'd4:       rsp_stall <= (hold_left != 0) || ($urandom_range(0, 7) != 0);
                3'd5:       rsp_stall <= (hold_left != 0) || cycle_count[3];
                default:    rsp_stall <= (hold_left != 0) || ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sequential_list_engine: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        traffic_phase_e           phase;
        int unsigned              phase_left;
        int unsigned              pick;
        int unsigned              p;
        logic [MODE_W-1:0]        m;
        logic signed [WORD_W-1:0] v;

        // directed: find, pops, erase, modify and a bad insert on an empty list first
        add_req(MODE_FIND,       0, '0);
        add_req(MODE_POP_BACK,   0, '0);
        add_req(MODE_POP_FRONT,  0, '0);
        add_req(MODE_ERASE,      0, '0);
        add_req(MODE_MODIFY,     0, '1);
        add_req(MODE_INSERT,     1, 32'sd5);         // past the end of an empty list
        // build a small list with the extreme values
        add_req(MODE_INSERT,     0, WORD_MAX);
        add_req(MODE_PUSH_BACK,  0, WORD_MIN);
        add_req(MODE_PUSH_FRONT, 0, '0);
        add_req(MODE_PUSH_BACK,  0, '1);
        add_req(MODE_INSERT,     POS_MAX, 32'sd1);   // bad position, all position bits set
        add_req(MODE_INSERT,     4, 32'sh55555555);  // at the end
        add_req(MODE_INSERT,     2, 32'shAAAAAAAA);  // in the middle
        add_req(MODE_FIND,       0, WORD_MIN);
        add_req(MODE_FIND,       0, 32'sd12345);
        add_req(MODE_MODIFY,     1, 32'sh0F0F0F0F);
        add_req(MODE_MODIFY,     6, '0);             // one past the last entry
        add_req(MODE_MODIFY,     POS_MAX, '0);
        add_req(MODE_ERASE,      6, '0);
        add_req(MODE_ERASE,      2, '0);
        add_req(MODE_ERASE,      4, '0);             // the last entry
        add_req(MODE_POP_FRONT,  0, '0);
        add_req(MODE_POP_BACK,   0, '0);
        add_req(MODE_FIND,       0, '1);

        // random: mostly well-formed positions, some noise anywhere in the field
        phase      = PH_FILL;
        phase_left = 0;
        while (pending_q.size() < ITEM_TOTAL)
        begin
            pick = $urandom_range(0, 9);
            if (phase == PH_FILL && pick < 7)
            begin
                case ($urandom_range(0, 2))
                    0:       m = MODE_PUSH_BACK;
                    1:       m = MODE_PUSH_FRONT;
                    default: m = MODE_INSERT;
                endcase
            end
            else if (phase == PH_DRAIN && pick < 7)
            begin
                case ($urandom_range(0, 2))
                    0:       m = MODE_POP_BACK;
                    1:       m = MODE_POP_FRONT;
                    default: m = MODE_ERASE;
                endcase
            end
            else
                m = MODE_W'($urandom_range(MODE_PUSH_BACK, MODE_MODIFY));

            if ($urandom_range(0, 6) == 0)
                p = $urandom_range(0, POS_MAX);
            else if (m == MODE_INSERT)
                p = $urandom_range(0, (gen_fill < DEPTH) ? gen_fill : DEPTH - 1);
            else
                p = (gen_fill == 0) ? 0 : $urandom_range(0, gen_fill - 1);

            pick = $urandom_range(0, 9);
            if (pick < 4 && recent_vals.size() != 0)
                v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
            else if (pick == 4)
                v = ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
            else
                v = $urandom;

            add_req(m, p, v);

            case (phase)
                PH_FILL:
                begin
                    if (gen_fill == DEPTH)
                    begin
                        phase      = PH_HIGH;
                        phase_left = $urandom_range(15, 40);
                    end
                end
                PH_HIGH:
                begin
                    if (phase_left == 0)
                        phase = PH_DRAIN;
                    else
                        phase_left--;
                end
                PH_DRAIN:
                begin
                    if (gen_fill == 0)
                    begin
                        phase      = PH_LOW;
                        phase_left = $urandom_range(5, 20);
                    end
                end
                default:
                begin
                    if (phase_left == 0)
                        phase = PH_FILL;
                    else
                        phase_left--;
                end
            endcase
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // everything offered, accepted and answered
        while (pending_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
            @(posedge clk);
        // let any stray response word show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("sequential_list_engine: match");
        else
            $display("sequential_list_engine: mismatch");
        $finish;
    end

endmodule
